[design/rgbdp_pkg.sv]
// Shared types and constants for the RGB to display pixel converter.
package rgbdp_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [6:0] alpha;
		logic       alpha_present;
	} pixel_in_t;

	typedef struct packed {
		logic        premultiplied;
		logic [6:0]  alpha_out;
		logic [23:0] pixel;
	} pixel_out_t;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned BPP_W  = 6;

	// register index = paddr[2]
	localparam logic REG_BPP    = 1'b0;
	localparam logic REG_LAYOUT = 1'b1;

	localparam logic [BPP_W-1:0] BPP_RESET = 6'd16;

	localparam logic [BPP_W-1:0] BPP_PASS  = 6'd0;
	localparam logic [BPP_W-1:0] BPP_MONO  = 6'd1;
	localparam logic [BPP_W-1:0] BPP_GREY_LO = 6'd2;
	localparam logic [BPP_W-1:0] BPP_GREY_HI = 6'd7;
	localparam logic [BPP_W-1:0] BPP_8     = 6'd8;
	localparam logic [BPP_W-1:0] BPP_12    = 6'd12;
	localparam logic [BPP_W-1:0] BPP_15    = 6'd15;
	localparam logic [BPP_W-1:0] BPP_16    = 6'd16;

	localparam logic LAYOUT_233 = 1'b0;
	localparam logic LAYOUT_222 = 1'b1;

	localparam logic [9:0] MONO_THRESHOLD = 10'd382;

	// floor(x / 765) == (x * GREY_RECIP) >> GREY_SHIFT for every x < 100859,
	// which covers the largest grey product 765 * 127
	localparam logic [19:0] GREY_RECIP = 20'd701799;
	localparam int unsigned GREY_SHIFT = 29;

endpackage

[design/rgb_to_display_pixel_convert.sv]
// Top level: RGB color to display pixel word converter.

// Takes one color request per clock unless in_stall holds it off. The request is
// captured in an input register, converted by a single pass of combinational
// logic (three 8x7 premultiply products, or a 17x20 reciprocal product for the
// grey levels) and held in a result register, from which the pixel word is
// presented. Throughput is one request per cycle while out_stall is low;
// out_stall backs up into in_stall only when both registers are full. With alpha
// present the channels are premultiplied and the flag set, whatever the depth.
// bits_per_pixel (offset 0x0, reset 16) and eight_bit_layout (offset 0x4,
// reset 0) must be written only while no request is in flight.
module rgb_to_display_pixel_convert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rgbdp_pkg::pixel_in_t                in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rgbdp_pkg::pixel_out_t               out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rgbdp_pkg::ADDR_W-1:0]        paddr,
	input  logic [rgbdp_pkg::DATA_W-1:0]        pwdata,
	output logic [rgbdp_pkg::DATA_W-1:0]        prdata,
	output logic                                pready
);

	logic [rgbdp_pkg::BPP_W-1:0] bpp_q;
	logic                        layout_q;

	rgbdp_pkg::pixel_in_t  data_s1;
	logic                  valid_s1;
	rgbdp_pkg::pixel_out_t data_s2;
	logic                  valid_s2;
	rgbdp_pkg::pixel_out_t result;

	logic load_s2;
	logic load_s1;

	logic [9:0]  sum;
	logic [16:0] grey_x;
	logic [36:0] grey_prod;
	logic [14:0] prod_r;
	logic [14:0] prod_g;
	logic [14:0] prod_b;
	logic [23:0] opaque;
	logic [23:0] passthru;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= rgbdp_pkg::BPP_RESET;
			layout_q <= rgbdp_pkg::LAYOUT_233;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				rgbdp_pkg::REG_BPP:    bpp_q    <= pwdata[rgbdp_pkg::BPP_W-1:0];
				rgbdp_pkg::REG_LAYOUT: layout_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rgbdp_pkg::REG_BPP:
				prdata = {{(rgbdp_pkg::DATA_W-rgbdp_pkg::BPP_W){1'b0}}, bpp_q};
			rgbdp_pkg::REG_LAYOUT:
				prdata = {{(rgbdp_pkg::DATA_W-1){1'b0}}, layout_q};
			default:
				prdata = '0;
		endcase
	end

	// pipeline control
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (load_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid)
			data_s1 <= in_data;
		if (load_s2 && valid_s1)
			data_s2 <= result;
	end

	// conversion
	assign sum = 10'(data_s1.red) + 10'(data_s1.green) + 10'(data_s1.blue);
	// sum * (2^depth - 1) as shift and subtract
	assign grey_x = (17'(sum) << bpp_q[2:0]) - 17'(sum);
	assign grey_prod = 37'(grey_x) * 37'(rgbdp_pkg::GREY_RECIP);

	assign prod_r = 15'(data_s1.red)   * 15'(data_s1.alpha);
	assign prod_g = 15'(data_s1.green) * 15'(data_s1.alpha);
	assign prod_b = 15'(data_s1.blue)  * 15'(data_s1.alpha);

	assign passthru = {data_s1.red, data_s1.green, data_s1.blue};

	always_comb begin
		case (bpp_q) inside
			rgbdp_pkg::BPP_MONO:
				opaque = {23'd0, (sum >= rgbdp_pkg::MONO_THRESHOLD)};
			[rgbdp_pkg::BPP_GREY_LO:rgbdp_pkg::BPP_GREY_HI]:
				opaque = {17'd0, grey_prod[rgbdp_pkg::GREY_SHIFT+6:rgbdp_pkg::GREY_SHIFT]};
			rgbdp_pkg::BPP_8:
				if (layout_q == rgbdp_pkg::LAYOUT_222)
					opaque = {18'd0, data_s1.red[7:6], data_s1.green[7:6],
						data_s1.blue[7:6]};
				else
					opaque = {16'd0, data_s1.red[7:6], data_s1.green[7:5],
						data_s1.blue[7:5]};
			rgbdp_pkg::BPP_16:
				opaque = {8'd0, data_s1.red[7:3], data_s1.green[7:2], data_s1.blue[7:3]};
			rgbdp_pkg::BPP_15:
				opaque = {9'd0, data_s1.red[7:3], data_s1.green[7:3], data_s1.blue[7:3]};
			rgbdp_pkg::BPP_12:
				opaque = {12'd0, data_s1.red[7:4], data_s1.green[7:4], data_s1.blue[7:4]};
			default:
				opaque = passthru;
		endcase
	end

	always_comb begin
		if (data_s1.alpha_present) begin
			result.premultiplied = 1'b1;
			result.alpha_out     = data_s1.alpha;
			result.pixel         = {prod_r[14:7], prod_g[14:7], prod_b[14:7]};
		end else begin
			result.premultiplied = 1'b0;
			result.alpha_out     = 7'd0;
			result.pixel         = opaque;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
